// File: sv/pid_controller_pos_inc_assert.svh
// Assertion macros for the PID controller block.
// Depends on nothing; included by pid_controller_pos_inc, the RTL file that carries assertions.
`ifndef PID_CONTROLLER_POS_INC_ASSERT_SVH
`define PID_CONTROLLER_POS_INC_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define PID_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("PID controller assertion failed");

// Condition that must never be true outside reset.
`define PID_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("PID controller forbidden condition seen");

`else

`define PID_ASSERT(lbl, clk, rstn, prop)
`define PID_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: sv/pidpi_pkg.sv
// Shared types and constants of the PID controller block.
// Depends on nothing; used by pidpi_cfg and pid_controller_pos_inc.
`default_nettype none

package pidpi_pkg;

  // Field widths.
  localparam int ErrW     = 16;
  localparam int GainW    = 32;
  localparam int LimW     = 15;
  localparam int DriveW   = 48;
  localparam int HeldW    = 32;
  localparam int FracW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE         = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_INTEG_LIMIT  = 3'd4,
    REG_I_TERM_LIMIT = 3'd5,
    REG_OUT_LIMIT    = 3'd6
  } cfg_idx_e;

  // Controller form.
  typedef enum logic {
    MODE_POS = 1'b0,
    MODE_INC = 1'b1
  } mode_e;

  // Reset values of the limit registers, whole units.
  localparam logic [LimW-1:0] IntegLimitRst = 15'd200;
  localparam logic [LimW-1:0] ITermLimitRst = 15'd200;
  localparam logic [LimW-1:0] OutLimitRst   = 15'd6000;

  // Saturation bounds of the drive output.
  localparam logic signed [DriveW-1:0] DriveMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DriveW-1:0] DriveMin = 48'sh8000_0000_0000;

  // Configuration as seen by the datapath.
  typedef struct packed {
    mode_e                   mode;
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [LimW-1:0]         integ_limit;
    logic [LimW-1:0]         i_term_limit;
    logic [LimW-1:0]         out_limit;
  } cfg_t;

endpackage

`default_nettype wire

// File: sv/pidpi_cfg.sv
// Configuration register file of the PID controller: mode, gains and limits.
// Depends on pidpi_pkg.
`default_nettype none

module pidpi_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pidpi_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [pidpi_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output pidpi_pkg::cfg_t                        cfg_o
);
  import pidpi_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode a write; indexes past the last register are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_MODE:         cfg_d.mode         = mode_e'(cfg_wdata_i[0]);
        REG_GAIN_P:       cfg_d.gain_p       = $signed(cfg_wdata_i[GainW-1:0]);
        REG_GAIN_I:       cfg_d.gain_i       = $signed(cfg_wdata_i[GainW-1:0]);
        REG_GAIN_D:       cfg_d.gain_d       = $signed(cfg_wdata_i[GainW-1:0]);
        REG_INTEG_LIMIT:  cfg_d.integ_limit  = cfg_wdata_i[LimW-1:0];
        REG_I_TERM_LIMIT: cfg_d.i_term_limit = cfg_wdata_i[LimW-1:0];
        REG_OUT_LIMIT:    cfg_d.out_limit    = cfg_wdata_i[LimW-1:0];
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  // Register file with its reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= MODE_POS;
      cfg_q.gain_p       <= '0;
      cfg_q.gain_i       <= '0;
      cfg_q.gain_d       <= '0;
      cfg_q.integ_limit  <= IntegLimitRst;
      cfg_q.i_term_limit <= ITermLimitRst;
      cfg_q.out_limit    <= OutLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/pid_controller_pos_inc.sv
// Top level of the PID controller: handshakes, error state and the datapath pipeline.
// Depends on pidpi_pkg, pidpi_cfg and pid_controller_pos_inc_assert.svh.
`default_nettype none

// Discrete PID controller with a positional and an incremental form. Each error
// item yields one Q32.16 drive item; items may follow one another in every cycle
// while out_ready_i stays high, so the sustained rate is then one item per clock.
// The pipeline has four stages: operand selection and error-state update at
// acceptance, three signed 32-bit gain multipliers, the integral clamp with the
// partial sum, and the final sum with saturation, where the incremental held
// output is updated. Write configuration only while the block holds no item; a
// write to an index past the last register is ignored.
module pid_controller_pos_inc (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [pidpi_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [pidpi_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // Error items.
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [pidpi_pkg::ErrW-1:0] err_sample_i,
  // Drive items.
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [pidpi_pkg::DriveW-1:0]    drive_o
);
  import pidpi_pkg::*;

  `include "pid_controller_pos_inc_assert.svh"

  cfg_t cfg;

  pidpi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Stage valid bits and per-stage advance conditions.
  logic v1_q, v2_q, v3_q, v4_q;
  logic take1, take2, take3, take4;
  logic in_acc, out_acc, s2_load, s3_load, s4_load;

  assign take4   = !v4_q || out_ready_i;
  assign take3   = !v3_q || take4;
  assign take2   = !v2_q || take3;
  assign take1   = !v1_q || take2;
  assign in_acc  = in_valid_i && take1;
  assign s2_load = v1_q && take2;
  assign s3_load = v2_q && take3;
  assign s4_load = v3_q && take4;
  assign out_acc = v4_q && out_ready_i;

  assign in_ready_o  = take1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (take1) begin
        v1_q <= in_valid_i;
      end
      if (take2) begin
        v2_q <= v1_q;
      end
      if (take3) begin
        v3_q <= v2_q;
      end
      if (take4) begin
        v4_q <= v3_q;
      end
    end
  end

  // Error state, updated as each item is accepted.
  logic signed [ErrW-1:0]   err_sum_q, err_sum_d;
  logic signed [ErrW-1:0]   prev_err_q;
  logic signed [ErrW:0]     prev_delta_q;
  logic signed [HeldW-1:0]  held_out_q, held_out_d;

  logic signed [ErrW:0]     delta;
  logic signed [ErrW+1:0]   ddelta;
  logic signed [ErrW:0]     sum_e;
  logic signed [ErrW:0]     integ_lim;
  logic signed [ErrW:0]     op_p_d;
  logic signed [ErrW-1:0]   op_i_d;
  logic signed [ErrW+1:0]   op_d_d;

  // Differences, the clamped error sum and the multiplier operands of the form.
  always_comb begin
    delta     = {err_sample_i[ErrW-1], err_sample_i} - {prev_err_q[ErrW-1], prev_err_q};
    ddelta    = {delta[ErrW], delta} - {prev_delta_q[ErrW], prev_delta_q};
    sum_e     = {err_sum_q[ErrW-1], err_sum_q} + {err_sample_i[ErrW-1], err_sample_i};
    integ_lim = $signed({2'b00, cfg.integ_limit});
    if (sum_e > integ_lim) begin
      err_sum_d = integ_lim[ErrW-1:0];
    end else if (sum_e < -integ_lim) begin
      err_sum_d = ErrW'(-integ_lim);
    end else begin
      err_sum_d = sum_e[ErrW-1:0];
    end
    if (cfg.mode == MODE_POS) begin
      op_p_d = {err_sample_i[ErrW-1], err_sample_i};
      op_i_d = err_sum_d;
      op_d_d = {delta[ErrW], delta};
    end else begin
      op_p_d = delta;
      op_i_d = err_sample_i;
      op_d_d = ddelta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q    <= '0;
      prev_err_q   <= '0;
      prev_delta_q <= '0;
    end else if (in_acc) begin
      prev_err_q <= err_sample_i;
      if (cfg.mode == MODE_POS) begin
        err_sum_q <= err_sum_d;
      end else begin
        prev_delta_q <= delta;
      end
    end
  end

  // Stage 1: multiplier operands.
  logic signed [ErrW:0]   op_p_q;
  logic signed [ErrW-1:0] op_i_q;
  logic signed [ErrW+1:0] op_d_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_p_q <= op_p_d;
      op_i_q <= op_i_d;
      op_d_q <= op_d_d;
    end
  end

  // Stage 2: gain products, exact.
  localparam int ProdPW = GainW + ErrW + 1;
  localparam int ProdIW = GainW + ErrW;
  localparam int ProdDW = GainW + ErrW + 2;

  logic signed [ProdPW-1:0] prod_p_q;
  logic signed [ProdIW-1:0] prod_i_q;
  logic signed [ProdDW-1:0] prod_d_q;

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      prod_p_q <= cfg.gain_p * op_p_q;
      prod_i_q <= cfg.gain_i * op_i_q;
      prod_d_q <= cfg.gain_d * op_d_q;
    end
  end

  // Stage 3: integral term clamp in the positional form, and P plus D.
  localparam int PdW  = ProdDW + 1;
  localparam int SumW = PdW + 1;

  logic signed [ProdIW-1:0] i_lim;
  logic signed [ProdIW-1:0] i_term_d, i_term_q;
  logic signed [PdW-1:0]    pd_sum_q;

  always_comb begin
    i_lim = $signed({{(ProdIW-LimW-FracW){1'b0}}, cfg.i_term_limit, {FracW{1'b0}}});
    i_term_d = prod_i_q;
    if (cfg.mode == MODE_POS) begin
      if (prod_i_q > i_lim) begin
        i_term_d = i_lim;
      end else if (prod_i_q < -i_lim) begin
        i_term_d = -i_lim;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_load) begin
      i_term_q <= i_term_d;
      pd_sum_q <= {{(PdW-ProdPW){prod_p_q[ProdPW-1]}}, prod_p_q}
                + {{(PdW-ProdDW){prod_d_q[ProdDW-1]}}, prod_d_q};
    end
  end

  // Stage 4: final sum, held output and saturation.
  logic signed [SumW-1:0]   held_add;
  logic signed [SumW-1:0]   sum4;
  logic signed [SumW-1:0]   o_lim;
  logic signed [SumW-1:0]   drive_max_x, drive_min_x;
  logic signed [DriveW-1:0] drive_d, drive_q;

  always_comb begin
    held_add    = (cfg.mode == MODE_INC) ? {{(SumW-HeldW){held_out_q[HeldW-1]}}, held_out_q}
                                         : '0;
    sum4        = {pd_sum_q[PdW-1], pd_sum_q}
                + {{(SumW-ProdIW){i_term_q[ProdIW-1]}}, i_term_q}
                + held_add;
    o_lim       = $signed({{(SumW-LimW-FracW){1'b0}}, cfg.out_limit, {FracW{1'b0}}});
    drive_max_x = {{(SumW-DriveW){DriveMax[DriveW-1]}}, DriveMax};
    drive_min_x = {{(SumW-DriveW){DriveMin[DriveW-1]}}, DriveMin};
    held_out_d  = held_out_q;
    if (cfg.mode == MODE_INC) begin
      if (sum4 > o_lim) begin
        held_out_d = o_lim[HeldW-1:0];
      end else if (sum4 < -o_lim) begin
        held_out_d = HeldW'(-o_lim);
      end else begin
        held_out_d = sum4[HeldW-1:0];
      end
      drive_d = {{(DriveW-HeldW){held_out_d[HeldW-1]}}, held_out_d};
    end else begin
      if (sum4 > drive_max_x) begin
        drive_d = DriveMax;
      end else if (sum4 < drive_min_x) begin
        drive_d = DriveMin;
      end else begin
        drive_d = sum4[DriveW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_out_q <= '0;
    end else if (s4_load && cfg.mode == MODE_INC) begin
      held_out_q <= held_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_load) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

  // Checks on the error sum, the held output and pipeline occupancy.
  logic signed [ErrW:0]  err_sum_x;
  logic signed [HeldW:0] held_x;
  logic signed [HeldW:0] o_lim_x;

  assign err_sum_x = {err_sum_q[ErrW-1], err_sum_q};
  assign held_x    = {held_out_q[HeldW-1], held_out_q};
  assign o_lim_x   = $signed({{(HeldW+1-LimW-FracW){1'b0}}, cfg.out_limit, {FracW{1'b0}}});

  `PID_ASSERT(a_err_sum_bound, clk_i, rst_ni, (in_acc && cfg.mode == MODE_POS) |=> (err_sum_x <= $past(integ_lim) && err_sum_x >= -$past(integ_lim)))
  `PID_ASSERT(a_held_bound, clk_i, rst_ni, (s4_load && cfg.mode == MODE_INC) |=> (held_x <= $past(o_lim_x) && held_x >= -$past(o_lim_x)))
  `PID_ASSERT(a_occupancy, clk_i, rst_ni, 1'b1 |=> ($countones({v1_q, v2_q, v3_q, v4_q}) == $countones($past({v1_q, v2_q, v3_q, v4_q})) + $past(in_acc) - $past(out_acc)))
  `PID_ASSERT_NEVER(a_held_not_min, clk_i, rst_ni, held_out_q == {1'b1, {(HeldW-1){1'b0}}})

endmodule

`default_nettype wire
